>>> rtl/core/qzt_pkg.sv
// qzt_pkg: shared types, opcodes and sizes for the quad zone trigger table
// no dependencies
package qzt_pkg;

  localparam int NumSlots = 32;
  localparam int IdxW     = $clog2(NumSlots);
  // packed slot word: corners x, corners z, band, kind
  localparam int SlotW    = 64 + 64 + 8 + 8;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_WRITE    = 3'd1,
    OP_DEACT    = 3'd2,
    OP_READ     = 3'd3,
    OP_CHECK    = 3'd4,
    OP_MARK     = 3'd5,
    OP_MARK_DR  = 3'd6,
    OP_NOP      = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         slot_index;
    logic [63:0]        corners_x;
    logic [63:0]        corners_z;
    logic [7:0]         zone_band;
    logic [7:0]         zone_type;
    logic               zone_active;
    logic               zone_entered;
    logic signed [15:0] point_x;
    logic signed [15:0] point_z;
    logic [7:0]         point_band;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit_found;
    logic [5:0]  hit_index;
    logic [63:0] read_corners_x;
    logic [63:0] read_corners_z;
    logic [7:0]  read_band;
    logic [7:0]  read_type;
    logic        read_active;
    logic        read_entered;
  } rsp_t;

  // one edge cross product sign: 2 bits, nonzero and negative
  typedef struct packed {
    logic nz;
    logic neg;
  } csign_t;

endpackage

>>> rtl/core/qzt_if.sv
// qzt_if: valid/ready channel interfaces for requests, responses and config
// depends on qzt_pkg
interface qzt_req_if (input logic clk);
  logic          valid;
  logic          ready;
  qzt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qzt_rsp_if (input logic clk);
  logic          valid;
  logic          ready;
  qzt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qzt_cfg_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/qzt_ram.sv
// qzt_ram: generic single-port write, single-port read ram, registered read
// no dependencies
module qzt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/qzt_edge.sv
// qzt_edge: one edge cross product sign, exact in 35 bits, one register stage
// depends on qzt_pkg
module qzt_edge (
  input  logic               clk,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] az,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] bz,
  input  logic signed [15:0] px,
  input  logic signed [15:0] pz,
  output qzt_pkg::csign_t    sgn
);
  logic signed [16:0] ex, ez, dx, dz;
  logic signed [33:0] p0_r, p1_r;
  logic signed [34:0] cr;

  assign ex = 17'(bx) - 17'(ax);
  assign ez = 17'(bz) - 17'(az);
  assign dx = 17'(px) - 17'(ax);
  assign dz = 17'(pz) - 17'(az);

  // products registered before the subtract
  always_ff @(posedge clk) begin
    p0_r <= ex * dz;
    p1_r <= ez * dx;
  end

  assign cr      = 35'(p0_r) - 35'(p1_r);
  assign sgn.nz  = (cr != '0);
  assign sgn.neg = cr[34];
endmodule

>>> rtl/core/quad_zone_trigger_table.sv
// quad_zone_trigger_table: top level, slot memory, sequencer and response register
// depends on qzt_pkg, qzt_if, qzt_ram, qzt_edge
//
//  channel | dir | signals                 | accepted when
//  in_     | in  | in_valid/in_ready/data  | valid && ready
//  out_    | out | out_valid/out_ready     | valid && ready
//  cfg_    | in  | cfg_valid/cfg_ready     | valid && ready
//
// from one accepted request to the next: clear, write, deactivate, a bad index
// and opcode 7 pass through S_RD and S_OUT; read adds S_SWEEP between them.
// check and mark sweep every slot address in S_SWEEP, then drain the pipeline.
// the single slot ram read port paces the sweep; flags sit in flip-flops.
// reset clears flags and config; per-slot valid bits make unwritten slots read
// as zero, so no clearing pass is needed.
// a stalled response holds the block in S_OUT until out_ready goes high.
module quad_zone_trigger_table (
  input  logic            clk,
  input  logic            rst_n,
  qzt_req_if.sink         in_ch,
  qzt_rsp_if.source       out_ch,
  qzt_cfg_if.sink         cfg_ch
);
  localparam int N  = qzt_pkg::NumSlots;
  localparam int AW = qzt_pkg::IdxW;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_SWEEP, S_OUT} state_t;

  state_t         state_r;
  qzt_pkg::req_t  req_r;
  qzt_pkg::rsp_t  rsp_r;
  logic [7:0]     door_r;
  logic [N-1:0]   act_r, ent_r, vld_r;
  logic [AW:0]    cnt_r;   // issue counter
  logic [AW-1:0]  s1_idx_r, s2_idx_r;
  logic           s1_v_r, s2_v_r;
  logic           s2_act_r, s2_bmatch_r;

  // ram
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [qzt_pkg::SlotW-1:0] wdata, rdata, rd_m;

  qzt_ram #(.Width(qzt_pkg::SlotW), .Depth(N)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic in_idx_ok;
  assign in_idx_ok = (req_r.slot_index < 6'(N));

  assign we    = (state_r == S_RD) && (req_r.opcode == qzt_pkg::OP_WRITE) && in_idx_ok;
  assign waddr = req_r.slot_index[AW-1:0];
  assign wdata = {req_r.corners_x, req_r.corners_z, req_r.zone_band, req_r.zone_type};
  assign raddr = (state_r == S_SWEEP) ? cnt_r[AW-1:0] : req_r.slot_index[AW-1:0];

  logic rd_vld;
  logic [AW-1:0] rd_addr_r;
  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
  end
  // never-written slots read as zero
  assign rd_vld = vld_r[rd_addr_r];
  assign rd_m = rd_vld ? rdata : '0;

  // edge units on stage 1 data
  logic [63:0] cx, cz;
  logic [7:0]  rband, rkind;
  assign {cx, cz, rband, rkind} = rd_m;
  qzt_pkg::csign_t sg [4];

  for (genvar k = 0; k < 4; k++) begin : g_edge
    localparam int Nk = (k + 1) % 4;
    qzt_edge u_edge (
      .clk(clk),
      .ax(cx[16*k +: 16]),  .az(cz[16*k +: 16]),
      .bx(cx[16*Nk +: 16]), .bz(cz[16*Nk +: 16]),
      .px(req_r.point_x), .pz(req_r.point_z), .sgn(sg[k])
    );
  end

  logic any_pos, any_neg, in_quad, s2_hit;
  always_comb begin
    any_pos = 1'b0;
    any_neg = 1'b0;
    for (int k = 0; k < 4; k++) begin
      any_pos = any_pos | (sg[k].nz & ~sg[k].neg);
      any_neg = any_neg | (sg[k].nz & sg[k].neg);
    end
    in_quad = ~(any_pos & any_neg);
    s2_hit = s2_v_r & s2_act_r & s2_bmatch_r & in_quad;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = rsp_r;

  logic is_sweep_op;
  assign is_sweep_op = (req_r.opcode == qzt_pkg::OP_CHECK) ||
                       (req_r.opcode == qzt_pkg::OP_MARK) ||
                       (req_r.opcode == qzt_pkg::OP_MARK_DR);

  // response start value: bad index status for slot addressed opcodes
  logic idx_op;
  qzt_pkg::rsp_t rsp_start;
  assign idx_op = (req_r.opcode == qzt_pkg::OP_WRITE) ||
                  (req_r.opcode == qzt_pkg::OP_DEACT) ||
                  (req_r.opcode == qzt_pkg::OP_READ);
  always_comb begin
    rsp_start        = '0;
    rsp_start.status = idx_op && !in_idx_ok;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      ent_r   <= '0;
      vld_r   <= '0;
      door_r  <= '0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        door_r <= cfg_ch.data;
      end
      s1_v_r      <= (state_r == S_SWEEP) && (cnt_r < (AW+1)'(N));
      s1_idx_r    <= cnt_r[AW-1:0];
      s2_v_r      <= s1_v_r;
      s2_idx_r    <= s1_idx_r;
      s2_act_r    <= act_r[s1_idx_r] &&
                     ((req_r.opcode != qzt_pkg::OP_MARK_DR) || (rkind == door_r));
      s2_bmatch_r <= (rband == req_r.point_band);
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= in_ch.data;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          rsp_r <= rsp_start;
          // a read skips the sweep issue
          cnt_r <= (req_r.opcode == qzt_pkg::OP_READ) ? (AW+1)'(N) : '0;
          priority case (req_r.opcode)
            qzt_pkg::OP_CLEAR: begin
              act_r   <= '0;
              ent_r   <= '0;
              vld_r   <= '0;
              state_r <= S_OUT;
            end
            qzt_pkg::OP_WRITE, qzt_pkg::OP_DEACT, qzt_pkg::OP_READ: begin
              if (!in_idx_ok) begin
                state_r      <= S_OUT;
              end else if (req_r.opcode == qzt_pkg::OP_WRITE) begin
                vld_r[waddr] <= 1'b1;
                act_r[waddr] <= req_r.zone_active;
                ent_r[waddr] <= req_r.zone_entered;
                state_r      <= S_OUT;
              end else if (req_r.opcode == qzt_pkg::OP_DEACT) begin
                act_r[waddr] <= 1'b0;
                state_r      <= S_OUT;
              end else begin
                state_r <= S_SWEEP;  // wait in S_SWEEP for ram data
              end
            end
            qzt_pkg::OP_CHECK, qzt_pkg::OP_MARK, qzt_pkg::OP_MARK_DR: begin
              state_r <= S_SWEEP;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_SWEEP: begin
          if (!is_sweep_op) begin
            // read data available now
            rsp_r.read_corners_x <= cx;
            rsp_r.read_corners_z <= cz;
            rsp_r.read_band      <= rband;
            rsp_r.read_type      <= rkind;
            rsp_r.read_active    <= act_r[waddr];
            rsp_r.read_entered   <= ent_r[waddr];
            state_r              <= S_OUT;
          end else begin
            if (cnt_r < (AW+1)'(N+3)) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              state_r <= S_OUT;
            end
            if (s2_hit) begin
              if (req_r.opcode == qzt_pkg::OP_CHECK) begin
                if (!ent_r[s2_idx_r] && !rsp_r.hit_found) begin
                  rsp_r.hit_found <= 1'b1;
                  rsp_r.hit_index <= 6'(s2_idx_r);
                end
              end else begin
                ent_r[s2_idx_r] <= 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/qzt_checker.sv
// qzt_checker: port level assertions for quad_zone_trigger_table, bound to it
// depends on qzt_if
module qzt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic status,
  input logic hit_found,
  input logic [5:0] hit_index
);
  // no new request while a response is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during response");
  // a taken response frees the input next cycle
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready) else $error("no ready after response");
  // a hit never comes with bad index
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit_found |-> !status) else $error("hit with bad status");
  // no hit means index zero
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit_found |-> hit_index == 6'd0) else $error("stray hit index");
endmodule

bind quad_zone_trigger_table qzt_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .hit_found(out_ch.data.hit_found),
  .hit_index(out_ch.data.hit_index)
);
